>>> src/fast_exp_bit_trick_defines.svh
// assertion macros for the fast exp block
`ifndef FAST_EXP_BIT_TRICK_DEFINES_SVH
`define FAST_EXP_BIT_TRICK_DEFINES_SVH

// same-cycle implication, held off during reset
`define FEBT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define FEBT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/febt_pkg.sv
// constants and register indexes for the fast exp block
package febt_pkg;

   localparam int unsigned NUM_STAGES = 6;

   // 24-bit significand of the fp32 scale 12102203.0
   localparam logic [23:0] EXP_SCALE = 24'hB8AA3B;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
   localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] INT_MIN   = 32'h8000_0000;

   localparam logic [31:0] MAGIC_OFFSET_RESET = 32'd1065280000;
   localparam logic        HALVED_MODE_RESET  = 1'b1;

   typedef enum logic {
      REG_MAGIC_OFFSET = 1'b0,
      REG_HALVED_MODE  = 1'b1
   } csr_index_type;

endpackage

>>> src/fast_exp_bit_trick.sv
// fast exp approximation on fp32 bit patterns, six-stage pipeline
//
//   port group | dir  | handshake             | beat
//   req_       | in   | req_valid/req_ready   | req_x_bits
//   rsp_       | out  | rsp_valid/rsp_ready   | rsp_result_bits
//   csr_       | in   | csr_we                | csr_index, csr_wdata
//
// one beat per cycle sustained while the receiver holds rsp_ready high
// stages: scale multiply, round, integer convert and offset add,
// square multiply, align shift, round and pack
// each stage moves on when it is empty or the next one moves, so bubbles close up
// synchronous reset clears valid bits and loads the register defaults
`include "fast_exp_bit_trick_defines.svh"

module fast_exp_bit_trick (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_x_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_bits,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned NS = febt_pkg::NUM_STAGES;

   // configuration
   logic [31:0] magic_ff;
   logic        halved_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff  <= febt_pkg::MAGIC_OFFSET_RESET;
         halved_ff <= febt_pkg::HALVED_MODE_RESET;
      end else if (csr_we) begin
         unique case (febt_pkg::csr_index_type'(csr_index))
            febt_pkg::REG_MAGIC_OFFSET: magic_ff  <= csr_wdata;
            febt_pkg::REG_HALVED_MODE:  halved_ff <= csr_wdata[0];
            default:                    magic_ff  <= magic_ff;
         endcase
      end
   end

   // stage valids and enables
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] stage_en;

   always_comb begin
      stage_en[NS-1] = ~valid_ff[NS-1] | rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = ~valid_ff[i] | stage_en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_ready = stage_en[0];

   // stage 1: decode, halve, scale multiply
   logic [47:0] p1_ff, p1_in;
   logic [7:0]  e1_ff, e1_in;
   logic        sgn1_ff, nan1_ff, inf1_ff, zero1_ff;
   logic        nan1_in, inf1_in, zero1_in;
   logic [7:0]  x_exp;
   logic [22:0] x_frac;

   always_comb begin
      x_exp    = req_x_bits[30:23];
      x_frac   = req_x_bits[22:0];
      nan1_in  = (x_exp == 8'hFF) && (x_frac != '0);
      inf1_in  = (x_exp == 8'hFF) && (x_frac == '0);
      // subnormals, and the halved smallest normal, scale to below one
      zero1_in = (x_exp == 8'h00) || (halved_ff && (x_exp == 8'h01));
      e1_in    = (halved_ff && (x_exp != 8'hFF)) ? x_exp - 8'd1 : x_exp;
      p1_in    = {24'd0, 1'b1, x_frac} * {24'd0, febt_pkg::EXP_SCALE};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         p1_ff    <= p1_in;
         e1_ff    <= e1_in;
         sgn1_ff  <= req_x_bits[31];
         nan1_ff  <= nan1_in;
         inf1_ff  <= inf1_in;
         zero1_ff <= zero1_in;
      end
   end

   // stage 2: round product to 24 bits
   logic [24:0]       r2_ff, r2_in;
   logic signed [9:0] sh2_ff, sh2_in;
   logic              sgn2_ff, nan2_ff, inf2_ff, zero2_ff;
   logic [23:0]       keep2;
   logic              g2, st2;

   always_comb begin
      if (p1_ff[47]) begin
         keep2 = p1_ff[47:24];
         g2    = p1_ff[23];
         st2   = |p1_ff[22:0];
      end else begin
         keep2 = p1_ff[46:23];
         g2    = p1_ff[22];
         st2   = |p1_ff[21:0];
      end
      r2_in  = {1'b0, keep2} + 25'(g2 & (st2 | keep2[0]));
      // weight of the rounded integer's lsb
      sh2_in = $signed(10'({2'b0, e1_ff}) + 10'(p1_ff[47]) - 10'd127);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         r2_ff    <= r2_in;
         sh2_ff   <= sh2_in;
         sgn2_ff  <= sgn1_ff;
         nan2_ff  <= nan1_ff;
         inf2_ff  <= inf1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // stage 3: truncate to saturating int32, add offset
   logic [31:0] a3_ff, a3_in;
   logic [31:0] mag3, left3, t3;
   logic [9:0]  nsh3;
   logic        sat3;

   always_comb begin
      left3 = {7'd0, r2_ff} << sh2_ff[2:0];
      nsh3  = 10'(-sh2_ff);
      mag3  = '0;
      sat3  = 1'b0;
      priority if (nan2_ff || zero2_ff) begin
         mag3 = '0;
      end else if (inf2_ff || (sh2_ff >= 10'sd8)) begin
         sat3 = 1'b1;
      end else if (sh2_ff >= 10'sd0) begin
         mag3 = left3;
         sat3 = left3[31];
      end else if (nsh3 >= 10'd25) begin
         mag3 = '0;
      end else begin
         mag3 = {7'd0, r2_ff >> nsh3[4:0]};
      end
      if (sat3) begin
         t3 = sgn2_ff ? febt_pkg::INT_MIN : febt_pkg::INT_MAX;
      end else begin
         t3 = sgn2_ff ? (~mag3 + 32'd1) : mag3;
      end
      a3_in = t3 + magic_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         a3_ff <= a3_in;
      end
   end

   // stage 4: square significand
   logic [47:0] p4_ff, p4_in;
   logic [7:0]  e4_ff;
   logic [31:0] a4_ff;
   logic        nan4_ff, inf4_ff, zero4_ff;
   logic [23:0] m4;

   always_comb begin
      m4    = {1'b1, a3_ff[22:0]};
      p4_in = {24'd0, m4} * {24'd0, m4};
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         p4_ff    <= p4_in;
         e4_ff    <= a3_ff[30:23];
         a4_ff    <= a3_ff;
         nan4_ff  <= (a3_ff[30:23] == 8'hFF) && (a3_ff[22:0] != '0);
         inf4_ff  <= (a3_ff[30:23] == 8'hFF) && (a3_ff[22:0] == '0);
         // subnormal squares fall far below the smallest subnormal
         zero4_ff <= (a3_ff[30:23] == 8'h00);
      end
   end

   // stage 5: align for normal or subnormal result
   logic [23:0]        q5_ff, q5_in;
   logic               g5_ff, g5_in, st5_ff, st5_in;
   logic [9:0]         base5_ff, base5_in;
   logic [31:0]        a5_ff;
   logic               nan5_ff, inf5_ff, zero5_ff;
   logic signed [10:0] ksub5, knorm5;
   logic [5:0]         k5, km1_5;
   logic [47:0]        w5, mask5;

   always_comb begin
      knorm5 = p4_ff[47] ? 11'sd24 : 11'sd23;
      ksub5  = 11'sd151 - $signed({2'b0, e4_ff, 1'b0});
      if (ksub5 > knorm5) begin
         k5       = (ksub5 > 11'sd49) ? 6'd49 : 6'(ksub5);
         base5_in = '0;
      end else begin
         k5       = 6'(knorm5);
         base5_in = 10'(p4_ff[47]) + {1'b0, e4_ff, 1'b0} - 10'd128;
      end
      km1_5  = k5 - 6'd1;
      w5     = p4_ff >> km1_5;
      q5_in  = w5[24:1];
      g5_in  = w5[0];
      mask5  = (48'd1 << km1_5) - 48'd1;
      st5_in = |(p4_ff & mask5);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         q5_ff    <= q5_in;
         g5_ff    <= g5_in;
         st5_ff   <= st5_in;
         base5_ff <= base5_in;
         a5_ff    <= a4_ff;
         nan5_ff  <= nan4_ff;
         inf5_ff  <= inf4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   // stage 6: round, pack, select mode
   logic [31:0] out6_ff, out6_in;
   logic [24:0] q6;
   logic [33:0] sum6;

   always_comb begin
      q6   = {1'b0, q5_ff} + 25'(g5_ff & (st5_ff | q5_ff[0]));
      // rounding carry flows into the exponent field
      sum6 = {1'b0, base5_ff, 23'd0} + 34'(q6);
      priority if (!halved_ff) begin
         out6_in = a5_ff;
      end else if (nan5_ff) begin
         out6_in = febt_pkg::QNAN_BITS;
      end else if (inf5_ff) begin
         out6_in = febt_pkg::INF_BITS;
      end else if (zero5_ff) begin
         out6_in = '0;
      end else if (sum6 >= 34'(febt_pkg::INF_BITS)) begin
         out6_in = febt_pkg::INF_BITS;
      end else begin
         out6_in = sum6[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         out6_ff <= out6_in;
      end
   end

   assign rsp_valid       = valid_ff[NS-1];
   assign rsp_result_bits = out6_ff;

   `FEBT_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && req_ready, valid_ff[0], "accepted beat did not enter stage one")
   `FEBT_ASSERT_SAME(a_square_positive, clock, reset, rsp_valid && halved_ff, !rsp_result_bits[31], "squared result carries a sign")
   `FEBT_ASSERT_NEXT(a_s5_holds, clock, reset, valid_ff[4] && !stage_en[4], valid_ff[4] && $stable(q5_ff), "stalled align stage lost its beat")
   `FEBT_ASSERT_NEXT(a_out_moves, clock, reset, rsp_valid && rsp_ready && !valid_ff[4], !rsp_valid, "delivered beat repeated")

endmodule

>>> dv/tb.sv
// testbench for the fast exp block: directed table, random stream, bit-exact predictor
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_x_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_bits;
   logic        csr_we = 1'b0;
   febt_pkg::csr_index_type csr_index = febt_pkg::REG_MAGIC_OFFSET;
   logic [31:0] csr_wdata = '0;

   fast_exp_bit_trick uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_x_bits(req_x_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_bits(rsp_result_bits),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // local copy of the registers
   logic [31:0] magic_now = febt_pkg::MAGIC_OFFSET_RESET;
   logic        halved_now = febt_pkg::HALVED_MODE_RESET;

   logic [31:0] pending_exp[$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   bit          idle_on = 1'b1;

   typedef struct {
      logic [31:0] x;
      bit          known;
      logic [31:0] result;
   } dir_row_type;

   // x scaled by 12102203, one fp32 rounding, truncated into saturating int32
   function automatic logic [31:0] scaled_int(logic [31:0] x, bit halve);
      logic [63:0] prod, keep, rem, half, mag;
      int          e, m, s, k;
      bit          big;
      big = 1'b0;
      mag = '0;
      if (x[30:23] == 8'hFF) begin
         if (x[22:0] != 0) return 32'd0;
         return x[31] ? febt_pkg::INT_MIN : febt_pkg::INT_MAX;
      end
      prod = {40'd0, (x[30:23] != 0), x[22:0]} * {40'd0, febt_pkg::EXP_SCALE};
      e = ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 150 - (halve ? 1 : 0);
      if (prod == 0) return 32'd0;
      m = 0;
      for (int i = 0; i < 64; i++) if (prod[i]) m = i;
      if (m > 23) begin
         s = m - 23;
         keep = prod >> s;
         rem = prod & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && keep[0])) keep = keep + 1;
         k = e + s;
      end else begin
         keep = prod;
         k = e;
      end
      if (k >= 0) begin
         if (k > 39) big = 1'b1;
         else mag = keep << k;
      end else begin
         mag = (-k >= 64) ? 64'd0 : keep >> (-k);
      end
      if (big || mag >= 64'h8000_0000) return x[31] ? febt_pkg::INT_MIN : febt_pkg::INT_MAX;
      return x[31] ? -mag[31:0] : mag[31:0];
   endfunction

   // fp32 square, round to nearest even, subnormals kept
   function automatic logic [31:0] fp_square(logic [31:0] r);
      logic [63:0] sq, keep, rem, half;
      int          e, m, lsb, s;
      if (r[30:23] == 8'hFF) return (r[22:0] != 0) ? febt_pkg::QNAN_BITS : febt_pkg::INF_BITS;
      if (r[30:0] == 0) return 32'd0;
      sq = {40'd0, (r[30:23] != 0), r[22:0]} * {40'd0, (r[30:23] != 0), r[22:0]};
      e = ((r[30:23] == 0) ? 1 : int'(r[30:23])) - 150;
      m = 0;
      for (int i = 0; i < 64; i++) if (sq[i]) m = i;
      lsb = m + 2 * e - 23;
      if (lsb < -149) lsb = -149;
      s = lsb - 2 * e;
      if (s <= 0) begin
         keep = sq << (-s);
      end else if (s > 50) begin
         keep = 0;
      end else begin
         keep = sq >> s;
         rem = sq & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && keep[0])) keep = keep + 1;
      end
      if (keep >= 64'h100_0000) begin
         keep = keep >> 1;
         lsb = lsb + 1;
      end
      if (keep >= 64'h80_0000) begin
         if (lsb + 150 >= 255) return febt_pkg::INF_BITS;
         return {1'b0, 8'(lsb + 150), keep[22:0]};
      end
      return {9'd0, keep[22:0]};
   endfunction

   function automatic logic [31:0] exp_approx(logic [31:0] x);
      if (halved_now) return fp_square(scaled_int(x, 1'b1) + magic_now);
      return scaled_int(x, 1'b0) + magic_now;
   endfunction

   // scoreboard on the handshakes, sampled before the edge updates
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && req_ready) pending_exp.push_back(exp_approx(req_x_bits));
         if (rsp_valid && rsp_ready) begin
            if (pending_exp.size() == 0) begin
               $error("result_bits: nothing expected, got %h", rsp_result_bits);
               errors <= errors + 1;
            end else begin
               if (pending_exp[0] !== rsp_result_bits) begin
                  $error("result_bits: expected %h, got %h", pending_exp[0], rsp_result_bits);
                  errors <= errors + 1;
               end
               void'(pending_exp.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // receiver stalls in bursts
   initial begin
      @(negedge reset);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic write_reg(febt_pkg::csr_index_type idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == febt_pkg::REG_MAGIC_OFFSET) magic_now = data;
      else halved_now = data[0];
   endtask

   task automatic send_beat(logic [31:0] x);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_bits <= x;
      do @(posedge clock); while (!req_ready);
   endtask

   // waits for a clock edge before checking the queue, so the last accepted beat is already counted
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_exp.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [31:0] random_x();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v[30:23] = 8'($urandom_range(110, 134));   // useful range
         4:          v[30:23] = 8'($urandom_range(135, 160));   // saturation region
         5:          v[30:23] = 8'hFF;                           // inf and nan
         6:          v[30:23] = 8'($urandom_range(0, 1));        // subnormal and near
         7:          v[22:0] = $urandom_range(0, 3) == 0 ? 23'd0 : v[22:0];
         default: ;
      endcase
      return v;
   endfunction

   dir_row_type dir_rows[22] = '{
      '{32'h7FC0_0000, 1'b1, 32'd1065280000},
      '{32'hFFFF_FFFF, 1'b1, 32'd1065280000},
      '{32'h0000_0000, 1'b1, 32'd1065280000},
      '{32'h8000_0000, 1'b1, 32'd1065280000},
      '{32'h7F80_0000, 1'b1, febt_pkg::INT_MAX + 32'd1065280000},
      '{32'hFF80_0000, 1'b1, febt_pkg::INT_MIN + 32'd1065280000},
      '{32'h7F7F_FFFF, 1'b1, febt_pkg::INT_MAX + 32'd1065280000},
      '{32'hFF7F_FFFF, 1'b1, febt_pkg::INT_MIN + 32'd1065280000},
      '{32'h0000_0001, 1'b1, 32'd1065280000},
      '{32'h807F_FFFF, 1'b1, 32'd1065280000},
      '{32'h3F80_0000, 1'b0, 32'd0},
      '{32'hBF80_0000, 1'b0, 32'd0},
      '{32'h4200_0000, 1'b0, 32'd0},
      '{32'hC2B0_0000, 1'b0, 32'd0},
      '{32'h4331_7218, 1'b0, 32'd0},
      '{32'h4331_7217, 1'b0, 32'd0},
      '{32'hC331_7218, 1'b0, 32'd0},
      '{32'h4330_0000, 1'b0, 32'd0},
      '{32'h3400_0000, 1'b0, 32'd0},
      '{32'h00FF_FFFF, 1'b0, 32'd0},
      '{32'h5555_5555, 1'b0, 32'd0},
      '{32'hAAAA_AAAA, 1'b0, 32'd0}
   };

   initial begin
      logic [31:0] magic_set[6];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // plain mode, reset offset: extremes read straight off
      write_reg(febt_pkg::REG_HALVED_MODE, 32'd0);
      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].x);
         if (dir_rows[i].known && exp_approx(dir_rows[i].x) !== dir_rows[i].result) begin
            $error("result_bits: expected %h, got %h", dir_rows[i].result,
                   exp_approx(dir_rows[i].x));
            errors++;
         end
      end
      drain();
      write_reg(febt_pkg::REG_HALVED_MODE, 32'd1);
      foreach (dir_rows[i]) send_beat(dir_rows[i].x);
      drain();

      magic_set = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, $urandom,
                    32'h3F80_0000 - 32'd366393, febt_pkg::MAGIC_OFFSET_RESET};
      for (int p = 0; p < 12; p++) begin
         write_reg(febt_pkg::REG_MAGIC_OFFSET, magic_set[p % 6]);
         write_reg(febt_pkg::REG_HALVED_MODE, 32'(p & 1));
         if (p == 11) idle_on = 1'b0;
         for (int n = 0; n < 130; n++) begin
            send_beat(random_x());
            // sender holds off once until the pipe is empty
            if (p == 3 && n == 60) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_exp.size() != 0);
            end
         end
         drain();
      end

      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
